[sv/tkiq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkiq_pkg
// Types, codes and the character table of the keystroke injection queue.
// ----------------------------------------------------------------------------
package tkiq_pkg;

    typedef enum logic [1:0] {
        OP_TAP   = 2'd0,
        OP_TYPE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_HOLD_FRAMES = 2'd0,
        CFG_GAP_FRAMES  = 2'd1,
        CFG_SHIFT_ROW   = 2'd2,
        CFG_SHIFT_COL   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_SHIFT = 2'd2
    } t_bk_state;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;

    typedef struct packed {
        logic       shift;
        logic [2:0] row;
        logic [2:0] col;
    } t_key;

    typedef struct packed {
        logic mapped;
        t_key key;
    } t_map;

    typedef struct packed {
        t_op  op;
        logic mapped;
        t_key key;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic       accepted;
        logic       char_mapped;
        logic [2:0] row;
        logic [2:0] col;
        logic       pressed;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [7:0] hold_frames;
        logic [7:0] gap_frames;
        logic [2:0] shift_row;
        logic [2:0] shift_col;
    } t_cfg;

    function automatic t_map f_hit(input logic [2:0] row, input logic [2:0] col,
                                   input logic shift);
        t_map m;
        m.mapped    = 1'b1;
        m.key.shift = shift;
        m.key.row   = row;
        m.key.col   = col;
        return m;
    endfunction

    // newline becomes CR and upper case folds to lower before the lookup
    function automatic t_map f_char_map(input logic [7:0] ch_in);
        logic [7:0] c;
        t_map       m;
        c = ch_in;
        m = '0;
        if (c == CH_LF) begin
            c = CH_CR;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            c = c + CH_CASE_OFS;
        end
        case (c)
            CH_CR: m = f_hit(3'd0, 3'd1, 1'b0);
            "3": m = f_hit(3'd1, 3'd0, 1'b0);
            "w": m = f_hit(3'd1, 3'd1, 1'b0);
            "a": m = f_hit(3'd1, 3'd2, 1'b0);
            "4": m = f_hit(3'd1, 3'd3, 1'b0);
            "z": m = f_hit(3'd1, 3'd4, 1'b0);
            "s": m = f_hit(3'd1, 3'd5, 1'b0);
            "e": m = f_hit(3'd1, 3'd6, 1'b0);
            "5": m = f_hit(3'd2, 3'd0, 1'b0);
            "r": m = f_hit(3'd2, 3'd1, 1'b0);
            "d": m = f_hit(3'd2, 3'd2, 1'b0);
            "6": m = f_hit(3'd2, 3'd3, 1'b0);
            "c": m = f_hit(3'd2, 3'd4, 1'b0);
            "f": m = f_hit(3'd2, 3'd5, 1'b0);
            "t": m = f_hit(3'd2, 3'd6, 1'b0);
            "x": m = f_hit(3'd2, 3'd7, 1'b0);
            "7": m = f_hit(3'd3, 3'd0, 1'b0);
            "y": m = f_hit(3'd3, 3'd1, 1'b0);
            "g": m = f_hit(3'd3, 3'd2, 1'b0);
            "8": m = f_hit(3'd3, 3'd3, 1'b0);
            "b": m = f_hit(3'd3, 3'd4, 1'b0);
            "h": m = f_hit(3'd3, 3'd5, 1'b0);
            "u": m = f_hit(3'd3, 3'd6, 1'b0);
            "v": m = f_hit(3'd3, 3'd7, 1'b0);
            "9": m = f_hit(3'd4, 3'd0, 1'b0);
            "i": m = f_hit(3'd4, 3'd1, 1'b0);
            "j": m = f_hit(3'd4, 3'd2, 1'b0);
            "0": m = f_hit(3'd4, 3'd3, 1'b0);
            "m": m = f_hit(3'd4, 3'd4, 1'b0);
            "k": m = f_hit(3'd4, 3'd5, 1'b0);
            "o": m = f_hit(3'd4, 3'd6, 1'b0);
            "n": m = f_hit(3'd4, 3'd7, 1'b0);
            "+": m = f_hit(3'd5, 3'd0, 1'b0);
            "p": m = f_hit(3'd5, 3'd1, 1'b0);
            "l": m = f_hit(3'd5, 3'd2, 1'b0);
            "-": m = f_hit(3'd5, 3'd3, 1'b0);
            ".": m = f_hit(3'd5, 3'd4, 1'b0);
            ":": m = f_hit(3'd5, 3'd5, 1'b0);
            "@": m = f_hit(3'd5, 3'd6, 1'b0);
            ",": m = f_hit(3'd5, 3'd7, 1'b0);
            "*": m = f_hit(3'd6, 3'd1, 1'b0);
            ";": m = f_hit(3'd6, 3'd2, 1'b0);
            "=": m = f_hit(3'd6, 3'd5, 1'b0);
            "^": m = f_hit(3'd6, 3'd6, 1'b0);
            "/": m = f_hit(3'd6, 3'd7, 1'b0);
            "1": m = f_hit(3'd7, 3'd0, 1'b0);
            "2": m = f_hit(3'd7, 3'd3, 1'b0);
            " ": m = f_hit(3'd7, 3'd4, 1'b0);
            "q": m = f_hit(3'd7, 3'd6, 1'b0);
            "!": m = f_hit(3'd7, 3'd0, 1'b1);
            8'h22: m = f_hit(3'd7, 3'd3, 1'b1); // double quote
            "#": m = f_hit(3'd1, 3'd0, 1'b1);
            "$": m = f_hit(3'd1, 3'd3, 1'b1);
            "%": m = f_hit(3'd2, 3'd0, 1'b1);
            "&": m = f_hit(3'd2, 3'd3, 1'b1);
            8'h27: m = f_hit(3'd3, 3'd0, 1'b1); // apostrophe
            "(": m = f_hit(3'd3, 3'd3, 1'b1);
            ")": m = f_hit(3'd4, 3'd0, 1'b1);
            "<": m = f_hit(3'd5, 3'd7, 1'b1);
            ">": m = f_hit(3'd5, 3'd4, 1'b1);
            "[": m = f_hit(3'd5, 3'd5, 1'b1);
            "]": m = f_hit(3'd6, 3'd2, 1'b1);
            "?": m = f_hit(3'd6, 3'd7, 1'b1);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[sv/timed_keystroke_injection_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_keystroke_injection_queue_top
// Keystroke queue played into an 8x8 keyboard matrix on frame ticks.
// ----------------------------------------------------------------------------
// Input channel: push an operation word (tap, type character, frame tick,
// clear) while full is low. Words land in a four-entry command FIFO after the
// character lookup, so the input side keeps taking words while the back end
// works.
// Result channel: a four-entry result FIFO; while empty is low the oldest
// result word is on the o_ ports, and pop takes it. last marks the final
// word caused by one input word.
// Back end: a tap, type or clear and a frame tick that changes nothing are
// handled in the idle state; a press or release also reads the key queue
// memory and then emits the key change, and a shifted key adds the shift
// key change. A status or clear word passes the command FIFO and the result
// FIFO; a key change also passes the key queue read register.
// A stalled receiver fills the result FIFO; the back end then waits until two
// slots are free, the command FIFO fills and full rises.
// Configuration: valid/ready write port, always ready; write only while idle.
// Reset empties both FIFOs and the key queue and loads the register defaults;
// key queue memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module timed_keystroke_injection_queue_top
    import tkiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_key_row,
    input  logic [2:0] i_key_col,
    input  logic       i_key_shift,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic       o_accepted,
    output logic       o_char_mapped,
    output logic [2:0] o_row,
    output logic [2:0] o_col,
    output logic       o_pressed,
    output logic       o_last,
    input  logic       valid,
    output logic       ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int FIFO_DEPTH = 4;

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_cmd;
    logic w_cmd_push;
    logic w_cmd_empty;
    logic w_cmd_pop;
    logic w_res_afull;
    logic w_res_push;
    logic w_res_full;
    t_res w_res_in;
    t_res w_res_out;

    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_frames <= 8'd2;
            r_cfg.gap_frames  <= 8'd2;
            r_cfg.shift_row   <= 3'd1;
            r_cfg.shift_col   <= 3'd7;
        end else if (valid && ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HOLD_FRAMES: r_cfg.hold_frames <= i_cfg_data;
                CFG_GAP_FRAMES:  r_cfg.gap_frames  <= i_cfg_data;
                CFG_SHIFT_ROW:   r_cfg.shift_row   <= i_cfg_data[2:0];
                CFG_SHIFT_COL:   r_cfg.shift_col   <= i_cfg_data[2:0];
                default:         r_cfg.hold_frames <= r_cfg.hold_frames;
            endcase
        end
    end

    tkiq_front u_front (
        .i_push      (push),
        .i_operation (i_operation),
        .i_key_row   (i_key_row),
        .i_key_col   (i_key_col),
        .i_key_shift (i_key_shift),
        .i_char_code (i_char_code),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_front_cmd)
    );

    tkiq_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .o_afull (),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd),
        .o_empty (w_cmd_empty)
    );

    tkiq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_afull (w_res_afull || w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    tkiq_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .o_afull (w_res_afull),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_kind        = w_res_out.kind;
    assign o_accepted    = w_res_out.accepted;
    assign o_char_mapped = w_res_out.char_mapped;
    assign o_row         = w_res_out.row;
    assign o_col         = w_res_out.col;
    assign o_pressed     = w_res_out.pressed;
    assign o_last        = w_res_out.last;

endmodule

[sv/tkiq_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkiq_fifo
// Small register FIFO with full, empty and an almost-full flag (under two free slots).
// ----------------------------------------------------------------------------
module tkiq_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_afull,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_slot [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_afull = (r_cnt >= CW'(DEPTH - 1));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

[sv/tkiq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkiq_front
// Accepts input words, maps typed characters and forms back-end commands.
// ----------------------------------------------------------------------------
module tkiq_front
    import tkiq_pkg::*;
(
    input  logic       i_push,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_key_row,
    input  logic [2:0] i_key_col,
    input  logic       i_key_shift,
    input  logic [7:0] i_char_code,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    t_op  w_op;
    t_map w_map;

    assign w_op       = t_op'(i_operation);
    assign w_map      = f_char_map(i_char_code);
    assign o_cmd_push = i_push;

    always_comb begin
        o_cmd    = '0;
        o_cmd.op = w_op;
        case (w_op)
            OP_TAP: begin
                o_cmd.key.shift = i_key_shift;
                o_cmd.key.row   = i_key_row;
                o_cmd.key.col   = i_key_col;
            end
            OP_TYPE: begin
                o_cmd.mapped = w_map.mapped;
                o_cmd.key    = w_map.key;
            end
            default: begin
                o_cmd.key = '0;
            end
        endcase
    end

endmodule

[sv/tkiq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkiq_back
// Key queue and frame timing: executes commands and emits result words.
// ----------------------------------------------------------------------------
module tkiq_back
    import tkiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_empty,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_afull,
    output logic o_res_push,
    output t_res o_res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_key          r_mem [QUEUE_DEPTH];
    t_key          r_rd_key;
    t_bk_state     r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_hold, n_hold;
    logic [7:0]    r_gap, n_gap;
    logic          r_holding, n_holding;
    logic          r_pressed, n_pressed;
    logic          w_we;
    logic          w_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_hold    <= '0;
            r_gap     <= '0;
            r_holding <= 1'b0;
            r_pressed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_hold    <= n_hold;
            r_gap     <= n_gap;
            r_holding <= n_holding;
            r_pressed <= n_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_tail] <= i_cmd.key;
        end
        if (w_re) begin
            r_rd_key <= r_mem[r_head];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_hold     = r_hold;
        n_gap      = r_gap;
        n_holding  = r_holding;
        n_pressed  = r_pressed;
        w_we       = 1'b0;
        w_re       = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            BK_IDLE: begin
                // start only with room for a shifted key pair downstream
                if (!i_cmd_empty && !i_res_afull) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_TAP, OP_TYPE: begin
                            o_res_push        = 1'b1;
                            o_res.kind        = KIND_STATUS;
                            o_res.last        = 1'b1;
                            o_res.char_mapped = (i_cmd.op == OP_TYPE) && i_cmd.mapped;
                            if (i_cmd.op == OP_TAP || i_cmd.mapped) begin
                                if (r_count < CW'(QUEUE_DEPTH)) begin
                                    w_we           = 1'b1;
                                    n_tail         = (r_tail == AW'(QUEUE_DEPTH - 1)) ?
                                                     '0 : r_tail + AW'(1);
                                    n_count        = r_count + CW'(1);
                                    o_res.accepted = 1'b1;
                                end
                            end else begin
                                // unmapped character: skip, still accepted
                                o_res.accepted = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (r_holding) begin
                                n_hold = r_hold - 8'd1;
                                if (r_hold == 8'd1) begin
                                    n_holding = 1'b0;
                                    n_head    = (r_head == AW'(QUEUE_DEPTH - 1)) ?
                                                '0 : r_head + AW'(1);
                                    n_gap     = i_cfg.gap_frames;
                                    if (r_count != '0) begin
                                        w_re      = 1'b1;
                                        n_count   = r_count - CW'(1);
                                        n_pressed = 1'b0;
                                        n_state   = BK_READ;
                                    end
                                end
                            end else if (r_gap != 8'd0) begin
                                n_gap = r_gap - 8'd1;
                            end else if (r_count != '0) begin
                                w_re      = 1'b1;
                                n_holding = 1'b1;
                                n_hold    = i_cfg.hold_frames;
                                n_pressed = 1'b1;
                                n_state   = BK_READ;
                            end
                        end
                        OP_CLEAR: begin
                            n_head     = '0;
                            n_tail     = '0;
                            n_count    = '0;
                            n_hold     = '0;
                            n_gap      = '0;
                            n_holding  = 1'b0;
                            o_res_push = 1'b1;
                            o_res.kind = KIND_CLEAR;
                            o_res.last = 1'b1;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                o_res_push    = 1'b1;
                o_res.kind    = KIND_KEY;
                o_res.row     = r_rd_key.row;
                o_res.col     = r_rd_key.col;
                o_res.pressed = r_pressed;
                o_res.last    = !r_rd_key.shift;
                n_state       = r_rd_key.shift ? BK_SHIFT : BK_IDLE;
            end
            BK_SHIFT: begin
                o_res_push    = 1'b1;
                o_res.kind    = KIND_KEY;
                o_res.row     = i_cfg.shift_row;
                o_res.col     = i_cfg.shift_col;
                o_res.pressed = r_pressed;
                o_res.last    = 1'b1;
                n_state       = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

[sv/tkiq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkiq_checker
// Port-level checks of the keystroke injection queue, bound to the top level.
// ----------------------------------------------------------------------------
module tkiq_checker
    import tkiq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_kind,
    input logic       o_row_dummy,
    input logic       o_pressed,
    input logic       o_last,
    input logic       o_accepted
);

    // a waiting word holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_pressed)
                              && $stable(o_last) && $stable(o_accepted)))
        else $error("result word changed while stalled");

    // reset leaves both sides idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

    // the shift change of a shifted key follows its key change at once
    a_shift_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_kind == KIND_KEY && !o_last) |=>
            (!empty && o_kind == KIND_KEY && o_pressed == $past(o_pressed)))
        else $error("shift change missing after shifted key");

    // a key change carries no enqueue status
    a_key_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_KEY) |-> (!o_accepted && !o_row_dummy))
        else $error("key change carries status bits");

endmodule

bind timed_keystroke_injection_queue_top tkiq_checker u_tkiq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_kind      (o_kind),
    .o_row_dummy (o_char_mapped),
    .o_pressed   (o_pressed),
    .o_last      (o_last),
    .o_accepted  (o_accepted)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed keystroke injection queue.
// ----------------------------------------------------------------------------
// A short directed table covers the taps, the typed characters (case folding,
// newline, unmapped bytes, shifted keys), the press/hold/release/gap timing
// and clear. Random words follow in phases with different register settings
// and idling on both sides. Each accepted word runs through a local
// prediction of the key queue and frame timing, and every result word popped
// from the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import tkiq_pkg::*;

    localparam int DEPTH = 64;
    localparam int QAW = $clog2(DEPTH);
    localparam int SETTLE_CYCLES = 20;
    localparam int N_DIRECTED = 24;
    localparam int N_CHARS = 63;
    localparam int CAW = $clog2(N_CHARS);

    // {character, shift, row, col}; the low 7 bits are written in octal as
    // shift, row, col
    localparam logic [14:0] CHAR_KEYS [N_CHARS] = '{
        {8'h0D, 7'o001},
        {"3", 7'o010}, {"w", 7'o011}, {"a", 7'o012}, {"4", 7'o013},
        {"z", 7'o014}, {"s", 7'o015}, {"e", 7'o016},
        {"5", 7'o020}, {"r", 7'o021}, {"d", 7'o022}, {"6", 7'o023},
        {"c", 7'o024}, {"f", 7'o025}, {"t", 7'o026}, {"x", 7'o027},
        {"7", 7'o030}, {"y", 7'o031}, {"g", 7'o032}, {"8", 7'o033},
        {"b", 7'o034}, {"h", 7'o035}, {"u", 7'o036}, {"v", 7'o037},
        {"9", 7'o040}, {"i", 7'o041}, {"j", 7'o042}, {"0", 7'o043},
        {"m", 7'o044}, {"k", 7'o045}, {"o", 7'o046}, {"n", 7'o047},
        {"+", 7'o050}, {"p", 7'o051}, {"l", 7'o052}, {"-", 7'o053},
        {".", 7'o054}, {":", 7'o055}, {"@", 7'o056}, {",", 7'o057},
        {"*", 7'o061}, {";", 7'o062}, {"=", 7'o065}, {"^", 7'o066},
        {"/", 7'o067},
        {"1", 7'o070}, {"2", 7'o073}, {" ", 7'o074}, {"q", 7'o076},
        {"!", 7'o170}, {8'h22, 7'o173}, {"#", 7'o110}, {"$", 7'o113},
        {"%", 7'o120}, {"&", 7'o123}, {8'h27, 7'o130}, {"(", 7'o133},
        {")", 7'o140}, {"<", 7'o157}, {">", 7'o154}, {"[", 7'o155},
        {"]", 7'o162}, {"?", 7'o167}
    };

    typedef struct packed {
        t_op        op;
        logic [2:0] row;
        logic [2:0] col;
        logic       shift;
        logic [7:0] ch;
        logic       typed;
        t_res       res;
    } t_stim;

    localparam t_res RES_PLAIN_ACK  = '{KIND_STATUS, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0, 1'b1};
    localparam t_res RES_MAPPED_ACK = '{KIND_STATUS, 1'b1, 1'b1, 3'd0, 3'd0, 1'b0, 1'b1};
    localparam t_res RES_CLEARED    = '{KIND_CLEAR, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0, 1'b1};

    // timing below assumes the reset register values: hold 2, gap 2
    localparam t_stim DIRECTED [N_DIRECTED] = '{
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TAP,   3'd0, 3'd0, 1'b0, 8'h00,      1'b1, RES_PLAIN_ACK},
        '{OP_TAP,   3'd7, 3'd7, 1'b1, 8'h00,      1'b1, RES_PLAIN_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, CH_UPPER_A, 1'b1, RES_MAPPED_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, CH_LF,      1'b1, RES_MAPPED_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, CH_UPPER_Z, 1'b1, RES_MAPPED_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, 8'h00,      1'b1, RES_PLAIN_ACK},
        '{OP_TYPE,  3'd7, 3'd7, 1'b1, 8'hFF,      1'b1, RES_PLAIN_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, "!",        1'b1, RES_MAPPED_ACK},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_CLEAR, 3'd0, 3'd0, 1'b0, 8'h00,      1'b1, RES_CLEARED},
        '{OP_TICK,  3'd0, 3'd0, 1'b0, 8'h00,      1'b0, '0},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, "?",        1'b1, RES_MAPPED_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, "@",        1'b1, RES_MAPPED_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, "[",        1'b1, RES_MAPPED_ACK},
        '{OP_TYPE,  3'd0, 3'd0, 1'b0, 8'h60,      1'b1, RES_PLAIN_ACK},
        '{OP_CLEAR, 3'd0, 3'd0, 1'b0, 8'h00,      1'b1, RES_CLEARED}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_operation = '0;
    logic [2:0] i_key_row = '0;
    logic [2:0] i_key_col = '0;
    logic       i_key_shift = 1'b0;
    logic [7:0] i_char_code = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_kind;
    logic       o_accepted;
    logic       o_char_mapped;
    logic [2:0] o_row;
    logic [2:0] o_col;
    logic       o_pressed;
    logic       o_last;
    logic       valid = 1'b0;
    logic       ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    // local copy of the block state
    t_cfg        cfg;
    t_key        key_store [DEPTH];
    int unsigned head_ptr;
    int unsigned queued;
    logic [7:0]  hold_left;
    logic [7:0]  gap_left;
    logic        holding;

    t_res        matrix_events [$];
    t_res        expected_events [$];
    int          failures = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    timed_keystroke_injection_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_operation(i_operation),
        .i_key_row(i_key_row),
        .i_key_col(i_key_col),
        .i_key_shift(i_key_shift),
        .i_char_code(i_char_code),
        .empty(empty),
        .pop(pop),
        .o_kind(o_kind),
        .o_accepted(o_accepted),
        .o_char_mapped(o_char_mapped),
        .o_row(o_row),
        .o_col(o_col),
        .o_pressed(o_pressed),
        .o_last(o_last),
        .valid(valid),
        .ready(ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_key_state();
        head_ptr  = 0;
        queued    = 0;
        hold_left = '0;
        gap_left  = '0;
        holding   = 1'b0;
    endfunction

    function automatic logic store_key(input t_key k);
        if (queued >= DEPTH) begin
            return 1'b0;
        end
        key_store[QAW'((head_ptr + queued) % DEPTH)] = k;
        queued++;
        return 1'b1;
    endfunction

    // key change for the head of the queue, plus the configured shift key when needed
    function automatic void emit_head(input logic down);
        t_key k;
        if (queued == 0) begin
            return;
        end
        k = key_store[QAW'(head_ptr)];
        matrix_events.push_back('{KIND_KEY, 1'b0, 1'b0, k.row, k.col, down, ~k.shift});
        if (k.shift) begin
            matrix_events.push_back('{KIND_KEY, 1'b0, 1'b0, cfg.shift_row, cfg.shift_col,
                                      down, 1'b1});
        end
    endfunction

    function automatic void predict_matrix_events(input t_stim w);
        logic [7:0] c;
        t_key       k;
        logic       hit;
        logic       ok;
        matrix_events.delete();
        case (w.op)
            OP_TAP: begin
                k  = '{w.shift, w.row, w.col};
                ok = store_key(k);
                matrix_events.push_back('{KIND_STATUS, ok, 1'b0, 3'd0, 3'd0, 1'b0, 1'b1});
            end
            OP_TYPE: begin
                c   = w.ch;
                hit = 1'b0;
                k   = '0;
                if (c == CH_LF) begin
                    c = CH_CR;
                end
                if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                    c = c + CH_CASE_OFS;
                end
                for (int i = 0; i < N_CHARS; i++) begin
                    if (!hit && CHAR_KEYS[i][14:7] == c) begin
                        hit = 1'b1;
                        k   = CHAR_KEYS[i][6:0];
                    end
                end
                // an unmapped character is skipped but still acknowledged
                ok = hit ? store_key(k) : 1'b1;
                matrix_events.push_back('{KIND_STATUS, ok, hit, 3'd0, 3'd0, 1'b0, 1'b1});
            end
            OP_TICK: begin
                if (holding) begin
                    // a zero hold count wraps, so the key stays down 256 ticks
                    hold_left = hold_left - 8'd1;
                    if (hold_left == 0) begin
                        emit_head(1'b0);
                        holding  = 1'b0;
                        head_ptr = (head_ptr + 1) % DEPTH;
                        if (queued != 0) begin
                            queued--;
                        end
                        gap_left = cfg.gap_frames;
                    end
                end else if (gap_left != 0) begin
                    gap_left = gap_left - 8'd1;
                end else if (queued != 0) begin
                    emit_head(1'b1);
                    holding   = 1'b1;
                    hold_left = cfg.hold_frames;
                end
            end
            default: begin
                clear_key_state();
                matrix_events.push_back(RES_CLEARED);
            end
        endcase
    endfunction

    task automatic send_word(input t_stim w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= w.op;
        i_key_row   <= w.row;
        i_key_col   <= w.col;
        i_key_shift <= w.shift;
        i_char_code <= w.ch;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_matrix_events(w);
        if (w.typed) begin
            expected_events.push_back(w.res);
        end else begin
            foreach (matrix_events[i]) begin
                expected_events.push_back(matrix_events[i]);
            end
        end
    endtask

    // drain, then let a trailing frame tick finish inside the block
    task automatic settle();
        while (expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] hold, input logic [7:0] gap,
                              input logic [2:0] srow, input logic [2:0] scol);
        t_cfg_idx   idx;
        logic [7:0] val;
        for (int n = 0; n < 4; n++) begin
            idx = t_cfg_idx'(n);
            // row and column registers see random upper bits
            val = 8'($urandom);
            case (idx)
                CFG_HOLD_FRAMES: val = hold;
                CFG_GAP_FRAMES:  val = gap;
                CFG_SHIFT_ROW:   val[2:0] = srow;
                default:         val[2:0] = scol;
            endcase
            valid       <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!ready) begin
                @(posedge i_clk);
            end
            case (idx)
                CFG_HOLD_FRAMES: cfg.hold_frames = val;
                CFG_GAP_FRAMES:  cfg.gap_frames = val;
                CFG_SHIFT_ROW:   cfg.shift_row = val[2:0];
                default:         cfg.shift_col = val[2:0];
            endcase
        end
        valid <= 1'b0;
    endtask

    task automatic run_random(input int n_words, input int enq_pct, input int tick_pct);
        t_stim w;
        int    pick;
        for (int n = 0; n < n_words; n++) begin
            w.row   = 3'($urandom);
            w.col   = 3'($urandom);
            w.shift = 1'($urandom);
            w.typed = 1'b0;
            w.res   = '0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    w.ch = CHAR_KEYS[CAW'($urandom_range(0, N_CHARS - 1))][14:7];
                6:       w.ch = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
                7:       w.ch = CH_LF;
                default: w.ch = 8'($urandom);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < enq_pct) begin
                w.op = $urandom_range(0, 1) ? OP_TYPE : OP_TAP;
            end else if (pick < enq_pct + tick_pct) begin
                w.op = OP_TICK;
            end else begin
                w.op = OP_CLEAR;
            end
            send_word(w);
        end
        push <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
        end
    endtask

    // result side: pop at random, compare each word with the oldest prediction
    initial begin
        t_res want;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    $error("result word with nothing expected: kind %0d", o_kind);
                    failures++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("char_mapped", want.char_mapped, o_char_mapped);
                    check_field("row", want.row, o_row);
                    check_field("col", want.col, o_col);
                    check_field("pressed", want.pressed, o_pressed);
                    check_field("last", want.last, o_last);
                end
            end
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        cfg = '{8'd2, 8'd2, 3'd1, 3'd7};
        clear_key_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_word(DIRECTED[n]);
        end
        push <= 1'b0;
        settle();

        // fastest timing, shift key in the corner
        write_regs(8'd1, 8'd0, 3'd0, 3'd0);
        run_random(80, 45, 50);
        settle();

        // slowest timing: the queue fills and rejects
        send_idle_pct = 72;
        write_regs(8'd255, 8'd255, 3'd7, 3'd7);
        run_random(90, 85, 15);
        settle();

        // zero hold wraps to a long press; mostly ticks
        send_idle_pct = 0;
        stall_pct     = 72;
        write_regs(8'd0, 8'd1, 3'd3, 3'd5);
        run_random(320, 5, 95);
        settle();

        send_idle_pct = 15;
        stall_pct     = 15;
        write_regs(8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)),
                   3'($urandom), 3'($urandom));
        run_random(60, 45, 52);
        settle();

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/tkiq_pkg.sv
sv/tkiq_fifo.sv
sv/tkiq_front.sv
sv/tkiq_back.sv
sv/timed_keystroke_injection_queue_top.sv
sv/tkiq_checker.sv
verif/tb.sv
